// ===== hw/rtl/sbsh_pkg.sv =====
// sbsh_pkg: shared types, constants and state encodings for the sha-1 byte stream hasher
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package sbsh_pkg;

    // one input transaction
    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       end_of_message;
    } t_in_item;

    // one result transaction
    typedef struct packed {
        logic [31:0] digest_word0;
        logic [31:0] digest_word1;
        logic [31:0] digest_word2;
        logic [31:0] digest_word3;
        logic [31:0] digest_word4;
    } t_out_item;

    // classified command held in the queue
    typedef struct packed {
        logic [7:0] data;
        logic       has_byte;
        logic       is_end;
    } t_cmd;

    // block hand-off request from the assembler to the compressor
    typedef struct packed {
        logic valid;
        logic last;
    } t_blk_req;

    // block assembler sequencer
    typedef enum logic [1:0] {
        A_IDLE,
        A_MARK,
        A_ZERO,
        A_LEN
    } t_asm_state;

    // compressor sequencer
    typedef enum logic [1:0] {
        C_IDLE,
        C_ROUND,
        C_ADD
    } t_core_state;

    localparam int BLOCK_BITS = 512;

    // initial chaining words
    localparam logic [31:0] H_INIT0 = 32'h67452301;
    localparam logic [31:0] H_INIT1 = 32'hEFCDAB89;
    localparam logic [31:0] H_INIT2 = 32'h98BADCFE;
    localparam logic [31:0] H_INIT3 = 32'h10325476;
    localparam logic [31:0] H_INIT4 = 32'hC3D2E1F0;

    // round constants
    localparam logic [31:0] K_ROUND0 = 32'h5A827999;
    localparam logic [31:0] K_ROUND1 = 32'h6ED9EBA1;
    localparam logic [31:0] K_ROUND2 = 32'h8F1BBCDC;
    localparam logic [31:0] K_ROUND3 = 32'hCA62C1D6;

    // round counter marks
    localparam logic [6:0] ROUND_Q1   = 7'd20;
    localparam logic [6:0] ROUND_Q2   = 7'd40;
    localparam logic [6:0] ROUND_Q3   = 7'd60;
    localparam logic [6:0] ROUND_LAST = 7'd79;

    // padding
    localparam logic [7:0] PAD_MARK     = 8'h80;
    localparam logic [7:0] PAD_ZERO     = 8'h00;
    localparam logic [6:0] PAD_LEN_POS  = 7'd56;
    localparam logic [2:0] LEN_BYTE_TOP = 3'd7;

endpackage

`default_nettype wire

// ===== hw/rtl/sha1_byte_stream_hasher.sv =====
// sha1_byte_stream_hasher: top level of the sha-1 byte stream hasher
// depends on sbsh_pkg, sbsh_front, sbsh_fifo, sbsh_block and sbsh_core
`timescale 1ns / 1ps
`default_nettype none

// Hashes a byte stream with standard SHA-1, one optional byte per input
// transaction; a transaction with end_of_message closes the message (after
// its byte, if any) and one result transaction later carries the five digest
// words. The hasher then starts the next message. The input stage and a short
// command queue keep taking transactions while the back end works, until the
// queue fills. The block assembler absorbs one byte per cycle into a 64-byte
// block while the block is not full and waiting for the compressor; the
// compressor runs one round per cycle, 80 rounds plus an add step per block,
// and overlaps with filling the next block, so long messages run at a rate
// set by the compressor's round loop. Closing a message makes the padding
// sequencer write the pad bytes (9 to 72 of them), with an extra step to
// switch to the length bytes, plus one or two compressions; the digest waits
// in an output register until taken, and only a second digest stalls behind it.
module sha1_byte_stream_hasher #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire sbsh_pkg::t_in_item   i_in_item,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output sbsh_pkg::t_out_item       o_out_item
);
    import sbsh_pkg::*;

    logic                  push, full, pop, cmd_valid, core_ready;
    t_cmd                  front_cmd, queue_cmd;
    t_blk_req              blk_req;
    logic [BLOCK_BITS-1:0] block;

    // input stage
    sbsh_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .o_push     (push),
        .o_cmd      (front_cmd),
        .i_full     (full)
    );

    // command queue
    sbsh_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (cmd_valid),
        .o_cmd   (queue_cmd)
    );

    // block assembly and padding
    sbsh_block u_block (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_valid  (cmd_valid),
        .i_cmd        (queue_cmd),
        .o_pop        (pop),
        .o_req        (blk_req),
        .o_block      (block),
        .i_core_ready (core_ready)
    );

    // compression and digest output
    sbsh_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (blk_req),
        .i_block     (block),
        .o_ready     (core_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/sbsh_front.sv =====
// sbsh_front: input stage that accepts transactions and classifies them into commands
// depends on sbsh_pkg; feeds sbsh_fifo
`timescale 1ns / 1ps
`default_nettype none

module sbsh_front (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire sbsh_pkg::t_in_item i_in_item,
    output logic                  o_push,
    output sbsh_pkg::t_cmd        o_cmd,
    input  wire logic             i_full
);
    import sbsh_pkg::*;

    logic  r_valid, n_valid;
    t_cmd  r_cmd, n_cmd;
    logic  accept;
    logic  useful;

    // transactions with neither flag change nothing and are dropped here
    always_comb begin
        o_in_ready = !r_valid || !i_full;
        o_push     = r_valid && !i_full;
        o_cmd      = r_cmd;
        accept     = i_in_valid && o_in_ready;
        useful     = i_in_item.byte_valid || i_in_item.end_of_message;
        n_valid    = (r_valid && !o_push) || (accept && useful);
        n_cmd      = r_cmd;
        if (accept) begin
            n_cmd.data     = i_in_item.data_byte;
            n_cmd.has_byte = i_in_item.byte_valid;
            n_cmd.is_end   = i_in_item.end_of_message;
        end
    end

    // command register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_cmd <= n_cmd;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/sbsh_fifo.sv =====
// sbsh_fifo: short command queue between the input stage and the block assembler
// depends on sbsh_pkg for the command type
`timescale 1ns / 1ps
`default_nettype none

module sbsh_fifo #(
    parameter int DEPTH = 4
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire sbsh_pkg::t_cmd i_cmd,
    output logic                o_full,
    input  wire logic           i_pop,
    output logic                o_valid,
    output sbsh_pkg::t_cmd      o_cmd
);
    import sbsh_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    t_cmd          r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          do_push, do_pop;

    always_comb begin
        o_full  = (r_count == CNT_FULL);
        o_valid = (r_count != '0);
        o_cmd   = r_mem[r_rd_ptr];
        do_push = i_push && !o_full;
        do_pop  = i_pop && o_valid;
    end

    // pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/sbsh_block.sv =====
// sbsh_block: block assembler, byte counting and padding sequencer
// depends on sbsh_pkg; takes commands from sbsh_fifo, hands full blocks to sbsh_core
`timescale 1ns / 1ps
`default_nettype none

module sbsh_block (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cmd_valid,
    input  wire sbsh_pkg::t_cmd       i_cmd,
    output logic                      o_pop,
    output sbsh_pkg::t_blk_req        o_req,
    output logic [sbsh_pkg::BLOCK_BITS-1:0] o_block,
    input  wire logic                 i_core_ready
);
    import sbsh_pkg::*;

    t_asm_state            r_state, n_state;
    logic [BLOCK_BITS-1:0] r_buf, n_buf;
    logic [6:0]            r_fill, n_fill;
    logic [63:0]           r_bytes, n_bytes;
    logic [63:0]           r_bits, n_bits;
    logic [2:0]            r_len_cnt, n_len_cnt;
    logic                  r_last, n_last;
    logic                  absorb;
    logic [7:0]            abyte;
    logic                  handoff;
    logic [63:0]           bytes_inc;

    // sequencer: message bytes, then marker, zeros and bit length
    always_comb begin
        n_state   = r_state;
        n_buf     = r_buf;
        n_fill    = r_fill;
        n_bytes   = r_bytes;
        n_bits    = r_bits;
        n_len_cnt = r_len_cnt;
        n_last    = r_last;
        absorb    = 1'b0;
        abyte     = PAD_ZERO;
        o_pop     = 1'b0;
        bytes_inc = r_bytes + 64'(i_cmd.has_byte);

        // full block goes to the compressor once it is free
        handoff     = r_fill[6] && i_core_ready;
        o_req.valid = handoff;
        o_req.last  = r_last;
        o_block     = r_buf;
        if (handoff) begin
            n_fill = '0;
            n_last = 1'b0;
        end

        unique case (r_state)
            A_IDLE: begin
                if (i_cmd_valid && !r_fill[6]) begin
                    o_pop = 1'b1;
                    if (i_cmd.has_byte) begin
                        absorb = 1'b1;
                        abyte  = i_cmd.data;
                    end
                    if (i_cmd.is_end) begin
                        n_bits  = {bytes_inc[60:0], 3'b000};
                        n_bytes = '0;
                        n_state = A_MARK;
                    end else begin
                        n_bytes = bytes_inc;
                    end
                end
            end
            A_MARK: begin
                if (!r_fill[6]) begin
                    absorb  = 1'b1;
                    abyte   = PAD_MARK;
                    n_state = A_ZERO;
                end
            end
            A_ZERO: begin
                if (!r_fill[6]) begin
                    if (r_fill == PAD_LEN_POS) begin
                        n_len_cnt = LEN_BYTE_TOP;
                        n_state   = A_LEN;
                    end else begin
                        absorb = 1'b1;
                    end
                end
            end
            A_LEN: begin
                if (!r_fill[6]) begin
                    absorb = 1'b1;
                    abyte  = r_bits[63:56];
                    n_bits = {r_bits[55:0], 8'h00};
                    if (r_len_cnt == '0) begin
                        n_last  = 1'b1;
                        n_state = A_IDLE;
                    end else begin
                        n_len_cnt = r_len_cnt - 1'b1;
                    end
                end
            end
            default: n_state = A_IDLE;
        endcase

        // shift one byte into the block
        if (absorb) begin
            n_buf  = {r_buf[BLOCK_BITS-9:0], abyte};
            n_fill = r_fill + 1'b1;
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= A_IDLE;
            r_fill    <= '0;
            r_bytes   <= '0;
            r_len_cnt <= '0;
            r_last    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_fill    <= n_fill;
            r_bytes   <= n_bytes;
            r_len_cnt <= n_len_cnt;
            r_last    <= n_last;
        end
        r_buf  <= n_buf;
        r_bits <= n_bits;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/sbsh_core.sv =====
// sbsh_core: 80-round compression, chaining words and digest output register
// depends on sbsh_pkg; takes blocks from sbsh_block
`timescale 1ns / 1ps
`default_nettype none

module sbsh_core (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire sbsh_pkg::t_blk_req         i_req,
    input  wire logic [sbsh_pkg::BLOCK_BITS-1:0] i_block,
    output logic                            o_ready,
    output logic                            o_out_valid,
    input  wire logic                       i_out_ready,
    output sbsh_pkg::t_out_item             o_out_item
);
    import sbsh_pkg::*;

    t_core_state r_state, n_state;
    logic [6:0]  r_round, n_round;
    logic        r_last, n_last;
    logic [31:0] r_h [5];
    logic [31:0] n_h [5];
    logic [31:0] r_v [5];
    logic [31:0] n_v [5];
    logic [31:0] r_w [16];
    logic [31:0] n_w [16];
    logic        r_out_valid, n_out_valid;
    t_out_item   r_out, n_out;
    logic [31:0] f_val, k_val, tmp, w_new, w_mix;
    logic [31:0] sum [5];

    assign o_ready     = (r_state == C_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // round function and schedule expansion
    always_comb begin
        if (r_round < ROUND_Q1) begin
            f_val = (r_v[1] & r_v[2]) | (~r_v[1] & r_v[3]);
            k_val = K_ROUND0;
        end else if (r_round < ROUND_Q2) begin
            f_val = r_v[1] ^ r_v[2] ^ r_v[3];
            k_val = K_ROUND1;
        end else if (r_round < ROUND_Q3) begin
            f_val = (r_v[1] & r_v[2]) | (r_v[1] & r_v[3]) | (r_v[2] & r_v[3]);
            k_val = K_ROUND2;
        end else begin
            f_val = r_v[1] ^ r_v[2] ^ r_v[3];
            k_val = K_ROUND3;
        end
        tmp   = {r_v[0][26:0], r_v[0][31:27]} + f_val + r_v[4] + k_val + r_w[0];
        w_mix = r_w[13] ^ r_w[8] ^ r_w[2] ^ r_w[0];
        w_new = {w_mix[30:0], w_mix[31]};
        for (int i = 0; i < 5; i++) begin
            sum[i] = r_h[i] + r_v[i];
        end
    end

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_round     = r_round;
        n_last      = r_last;
        n_h         = r_h;
        n_v         = r_v;
        n_w         = r_w;
        n_out_valid = r_out_valid;
        n_out       = r_out;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            C_IDLE: begin
                if (i_req.valid) begin
                    for (int i = 0; i < 16; i++) begin
                        n_w[i] = i_block[BLOCK_BITS-1-32*i -: 32];
                    end
                    n_v     = r_h;
                    n_last  = i_req.last;
                    n_round = '0;
                    n_state = C_ROUND;
                end
            end
            C_ROUND: begin
                n_v[0] = tmp;
                n_v[1] = r_v[0];
                n_v[2] = {r_v[1][1:0], r_v[1][31:2]};
                n_v[3] = r_v[2];
                n_v[4] = r_v[3];
                for (int i = 0; i < 15; i++) begin
                    n_w[i] = r_w[i+1];
                end
                n_w[15] = w_new;
                n_round = r_round + 1'b1;
                if (r_round == ROUND_LAST) begin
                    n_state = C_ADD;
                end
            end
            C_ADD: begin
                if (!r_last) begin
                    n_h     = sum;
                    n_state = C_IDLE;
                end else if (!r_out_valid || i_out_ready) begin
                    // final block: publish digest and restart the chain
                    n_out.digest_word0 = sum[0];
                    n_out.digest_word1 = sum[1];
                    n_out.digest_word2 = sum[2];
                    n_out.digest_word3 = sum[3];
                    n_out.digest_word4 = sum[4];
                    n_out_valid        = 1'b1;
                    n_h[0]             = H_INIT0;
                    n_h[1]             = H_INIT1;
                    n_h[2]             = H_INIT2;
                    n_h[3]             = H_INIT3;
                    n_h[4]             = H_INIT4;
                    n_state            = C_IDLE;
                end
            end
            default: n_state = C_IDLE;
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= C_IDLE;
            r_round     <= '0;
            r_last      <= 1'b0;
            r_out_valid <= 1'b0;
            r_h[0]      <= H_INIT0;
            r_h[1]      <= H_INIT1;
            r_h[2]      <= H_INIT2;
            r_h[3]      <= H_INIT3;
            r_h[4]      <= H_INIT4;
        end else begin
            r_state     <= n_state;
            r_round     <= n_round;
            r_last      <= n_last;
            r_out_valid <= n_out_valid;
            r_h         <= n_h;
        end
        r_v   <= n_v;
        r_w   <= n_w;
        r_out <= n_out;
    end

endmodule

`default_nettype wire
